// ===== rtl/aspd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aspd_pkg: shared types and constants of the sync pulse detector
// Field widths, register reset values, the tempo numerator, the register
// index codes, the controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package aspd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = 32;
	localparam int IND_W     = 16;
	localparam int PEAK_W    = 16;
	localparam int MAG_W     = 17;
	localparam int NUM_W     = 43;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = 6;

	// full phase * phase scale * pulses per quarter note
	localparam logic [63:0] TEMPO_NUM_FULL = 64'h7fff_ffff * 64'd32 * 64'd96;
	localparam logic [NUM_W-1:0] TEMPO_NUM = TEMPO_NUM_FULL[NUM_W-1:0];

	localparam logic [CFG_W-1:0] HIGH_THR_RST   = 16'h6fff;
	localparam logic [CFG_W-1:0] LOW_THR_RST    = 16'h1fff;
	localparam logic [CFG_W-1:0] MIN_HOLD_RST   = 16'h00ff;
	localparam logic [CFG_W-1:0] IND_RELOAD_RST = 16'h04ff;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIGH_THR,
		CFG_LOW_THR,
		CFG_MIN_HOLD,
		CFG_IND_RELOAD
	} aspd_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_DONE
	} aspd_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic commit;
	} aspd_cmd_t;

	typedef struct packed {
		logic pulse;
		logic div_last;
		logic out_free;
	} aspd_stat_t;

endpackage
`default_nettype wire

// ===== rtl/aspd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aspd channels: sample input and result output
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface aspd_in_if
	import aspd_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       first_in_block;

	modport source (output valid, action, sample, first_in_block, input ready);
	modport sink (input valid, action, sample, first_in_block, output ready);
endinterface

interface aspd_out_if
	import aspd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              sync_pulse;
	logic              start_request;
	logic [CNT_W-1:0]  tempo_increment;
	logic [CNT_W-1:0]  last_period;
	logic [IND_W-1:0]  indicator_count;
	logic              gate_closed;
	logic [PEAK_W-1:0] peak_level;

	modport source (output valid, sync_pulse, start_request, tempo_increment, last_period,
		indicator_count, gate_closed, peak_level, input ready);
	modport sink (input valid, sync_pulse, start_request, tempo_increment, last_period,
		indicator_count, gate_closed, peak_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/aspd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aspd_ctrl: sequencing state machine
// Takes an item, evaluates it, runs the divider on a pulse and commits the
// result once the output register has room.
// ----------------------------------------------------------------------------
module aspd_ctrl
	import aspd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output aspd_cmd_t       cmd,
	input  wire aspd_stat_t stat
);

	aspd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.pulse) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/aspd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aspd_dp: detector datapath
// Config registers, detector state, item latch, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module aspd_dp
	import aspd_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [CFG_IDX_W-1:0]       wr_index,
	input  wire logic [CFG_W-1:0]           wr_data,
	input  wire logic                       in_action,
	input  wire logic signed [SAMPLE_W-1:0] in_sample,
	input  wire logic                       in_first,
	input  wire aspd_cmd_t                  cmd,
	output aspd_stat_t                      stat,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic                            out_sync_pulse,
	output logic                            out_start_request,
	output logic [CNT_W-1:0]                out_tempo_increment,
	output logic [CNT_W-1:0]                out_last_period,
	output logic [IND_W-1:0]                out_indicator_count,
	output logic                            out_gate_closed,
	output logic [PEAK_W-1:0]               out_peak_level
);

	logic [CFG_W-1:0] high_thr_q, low_thr_q, min_hold_q, ind_reload_q;

	logic [CNT_W-1:0]  since_q, inc_q, period_q;
	logic              gate_q, armed_q;
	logic [IND_W-1:0]  ind_q;
	logic [PEAK_W-1:0] peak_q;

	logic             act_q, first_q;
	logic [MAG_W-1:0] mag_q;

	logic [CNT_W-1:0]     dvsr_q, rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] step_q;

	logic [CNT_W-1:0]  since_next, quo_sat;
	logic [CNT_W:0]    trial, diff;
	logic              ge, pulse, reopen;
	logic [IND_W-1:0]  ind_base, ind_next;
	logic [PEAK_W-1:0] peak_base, peak_next;
	logic [MAG_W-1:0]  mag_in;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q   <= HIGH_THR_RST;
			low_thr_q    <= LOW_THR_RST;
			min_hold_q   <= MIN_HOLD_RST;
			ind_reload_q <= IND_RELOAD_RST;
		end else if (wr_en) begin
			unique case (aspd_cfg_idx_t'(wr_index))
				CFG_HIGH_THR:   high_thr_q   <= wr_data;
				CFG_LOW_THR:    low_thr_q    <= wr_data;
				CFG_MIN_HOLD:   min_hold_q   <= wr_data;
				CFG_IND_RELOAD: ind_reload_q <= wr_data;
				default: ;
			endcase
		end
	end

	// magnitude, with the most negative sample giving 32768
	assign mag_in = in_sample[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(in_sample))
		: MAG_W'(in_sample);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= in_action;
			first_q <= in_first;
			mag_q   <= mag_in;
		end
	end

	// item evaluation
	assign since_next = (since_q == '1) ? since_q : since_q + CNT_W'(1);
	assign pulse      = !act_q && !gate_q && (mag_q > MAG_W'(high_thr_q));
	assign reopen     = gate_q && (mag_q < MAG_W'(low_thr_q))
		&& (since_next > CNT_W'(min_hold_q));
	assign ind_base   = pulse ? ind_reload_q : ind_q;
	assign ind_next   = (ind_base != '0) ? ind_base - IND_W'(1) : ind_base;
	assign peak_base  = first_q ? '0 : peak_q;
	assign peak_next  = (mag_q > MAG_W'(peak_base)) ? mag_q[PEAK_W-1:0] : peak_base;

	// restoring divider, one quotient bit per step; the trial never reaches
	// twice the divisor, so a clear borrow bit means it fits
	assign trial   = {rem_q, quo_q[NUM_W-1]};
	assign diff    = trial - {1'b0, dvsr_q};
	assign ge      = !diff[CNT_W];
	assign quo_sat = (|quo_q[NUM_W-1:CNT_W]) ? '1 : quo_q[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_start) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvsr_q <= since_next;
			rem_q  <= '0;
			quo_q  <= TEMPO_NUM;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	// detector state, updated on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q  <= '0;
			gate_q   <= 1'b0;
			inc_q    <= '0;
			period_q <= '0;
			ind_q    <= '0;
			armed_q  <= 1'b0;
			peak_q   <= '0;
		end else if (cmd.commit) begin
			if (act_q) begin
				armed_q <= 1'b1;
			end else begin
				since_q <= pulse ? '0 : since_next;
				ind_q   <= ind_next;
				peak_q  <= peak_next;
				if (pulse) begin
					inc_q    <= quo_sat;
					period_q <= since_next;
					gate_q   <= 1'b1;
					armed_q  <= 1'b0;
				end else if (reopen) begin
					gate_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_sync_pulse      <= pulse;
			out_start_request   <= pulse && armed_q;
			out_tempo_increment <= pulse ? quo_sat : inc_q;
			out_last_period     <= pulse ? since_next : period_q;
			out_indicator_count <= act_q ? ind_q : ind_next;
			out_gate_closed     <= act_q ? gate_q : (pulse || (gate_q && !reopen));
			out_peak_level      <= act_q ? peak_q : peak_next;
		end
	end

	assign stat.pulse    = pulse;
	assign stat.div_last = (step_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/audio_sync_pulse_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_sync_pulse_detector_unit: sync pulse detector with tempo measurement
// Hysteresis pulse detection on a sync input, period and tempo increment
// capture, indicator countdown, start-on-sync arming and block peak tracking.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  samples   in   valid/ready   action, sample, first_in_block
//  results   out  valid/ready   sync_pulse .. peak_level (one per transfer)
//  wr_*      in   wr_en only    wr_index, wr_data (no read-back)
//
//  An item without a pulse (including an arm request) is evaluated and
//  committed; one that fires a pulse first runs the restoring divider,
//  making one quotient bit per cycle over the 43-bit tempo numerator.
//  The next item is taken while the previous result sits in the output
//  register; a stalled output holds the controller before commit.
//  arst_n clears all detector state and loads register defaults.
// ----------------------------------------------------------------------------
module audio_sync_pulse_detector_unit
	import aspd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	aspd_in_if.sink                   samples,
	aspd_out_if.source                results,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data
);

	aspd_cmd_t  cmd;
	aspd_stat_t stat;

	// controller: sequence evaluate, divide and commit
	aspd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// datapath: state, divider and output register
	aspd_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.wr_en               (wr_en),
		.wr_index            (wr_index),
		.wr_data             (wr_data),
		.in_action           (samples.action),
		.in_sample           (samples.sample),
		.in_first            (samples.first_in_block),
		.cmd                 (cmd),
		.stat                (stat),
		.out_ready           (results.ready),
		.out_valid           (results.valid),
		.out_sync_pulse      (results.sync_pulse),
		.out_start_request   (results.start_request),
		.out_tempo_increment (results.tempo_increment),
		.out_last_period     (results.last_period),
		.out_indicator_count (results.indicator_count),
		.out_gate_closed     (results.gate_closed),
		.out_peak_level      (results.peak_level)
	);

`ifndef SYNTHESIS
	// one item in flight: no second transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("input taken while an item is in flight");

	// commit only into a free output register
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("result committed over a pending result");

	// a detected pulse always closes the gate
	a_pulse_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.sync_pulse) |-> results.gate_closed)
		else $error("pulse reported with gate open");

	// a start request comes only with a pulse
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.start_request) |-> results.sync_pulse)
		else $error("start request without pulse");

	// peak magnitude never exceeds 32768
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.peak_level <= PEAK_W'(32768)))
		else $error("peak level out of range");
`endif

endmodule
`default_nettype wire
